>>> hdl/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
`timescale 1ns / 1ps

package hpt_pkg;

   localparam int FIELD_W   = 32;
   localparam int CSR_W     = 64;
   localparam int NUM_REGS  = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int MAT_DIM   = 4;
   localparam int NUM_LANES = 3;

   typedef enum logic {
      REQ_POINT     = 1'b0,
      REQ_DIRECTION = 1'b1
   } req_kind_type;

   // Control that travels with each item through the matrix stages.
   typedef struct packed {
      logic         vld;
      req_kind_type kind;
   } stage_ctl_type;

   // Control that travels with each item through the divider stages.
   typedef struct packed {
      logic         vld;
      req_kind_type kind;
      logic         wz;
   } div_ctl_type;

   // Per-coordinate flags: sign of the result and quotient overflow.
   typedef struct packed {
      logic neg;
      logic ovf;
   } lane_flag_type;

endpackage

>>> hdl/hpt_xform.sv
// Matrix stages: input capture, entry products, rounding and row sums.
`timescale 1ns / 1ps

module hpt_xform #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32,
   parameter int SUM_W       = 2 * COORD_WIDTH - FRAC_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  hpt_pkg::stage_ctl_type        in_ctl,
   input  logic signed [COORD_WIDTH-1:0] in_coord [hpt_pkg::NUM_LANES],
   input  logic signed [COORD_WIDTH-1:0] mat [hpt_pkg::MAT_DIM][hpt_pkg::MAT_DIM],
   output hpt_pkg::stage_ctl_type        out_ctl,
   output logic signed [SUM_W-1:0]       row_sum [hpt_pkg::MAT_DIM]
);

   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int RND_W  = PROD_W - FRAC_BITS + 1;
   localparam logic signed [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

   hpt_pkg::stage_ctl_type        s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic signed [COORD_WIDTH-1:0] s1_coord_ff [hpt_pkg::NUM_LANES];
   logic signed [PROD_W-1:0]      s2_prod_in [hpt_pkg::MAT_DIM][hpt_pkg::NUM_LANES];
   logic signed [PROD_W-1:0]      s2_prod_ff [hpt_pkg::MAT_DIM][hpt_pkg::NUM_LANES];
   logic signed [COORD_WIDTH-1:0] s2_trans_ff [hpt_pkg::MAT_DIM];
   logic signed [SUM_W-1:0]       s3_pa_in [hpt_pkg::MAT_DIM];
   logic signed [SUM_W-1:0]       s3_pb_in [hpt_pkg::MAT_DIM];
   logic signed [SUM_W-1:0]       s3_pa_ff [hpt_pkg::MAT_DIM];
   logic signed [SUM_W-1:0]       s3_pb_ff [hpt_pkg::MAT_DIM];
   logic signed [SUM_W-1:0]       s4_sum_in [hpt_pkg::MAT_DIM];
   logic signed [SUM_W-1:0]       s4_sum_ff [hpt_pkg::MAT_DIM];
   logic signed [PROD_W:0]        biased [hpt_pkg::MAT_DIM][hpt_pkg::NUM_LANES];
   logic signed [RND_W-1:0]       rnd [hpt_pkg::MAT_DIM][hpt_pkg::NUM_LANES];
   logic signed [SUM_W-1:0]       trans_sel [hpt_pkg::MAT_DIM];

   always_comb begin
      for (int r = 0; r < hpt_pkg::MAT_DIM; r++) begin
         for (int c = 0; c < hpt_pkg::NUM_LANES; c++) begin
            s2_prod_in[r][c] = PROD_W'(mat[r][c]) * PROD_W'(s1_coord_ff[c]);
         end
      end
   end

   // Round half up: add half an LSB, then an arithmetic shift floors.
   always_comb begin
      for (int r = 0; r < hpt_pkg::MAT_DIM; r++) begin
         for (int c = 0; c < hpt_pkg::NUM_LANES; c++) begin
            biased[r][c] = (PROD_W + 1)'(s2_prod_ff[r][c]) + HALF_LSB;
            rnd[r][c]    = RND_W'(biased[r][c] >>> FRAC_BITS);
         end
         if (s2_ctl_ff.kind == hpt_pkg::REQ_DIRECTION) begin
            trans_sel[r] = '0;
         end else begin
            trans_sel[r] = SUM_W'(s2_trans_ff[r]);
         end
         s3_pa_in[r] = SUM_W'(rnd[r][0]) + SUM_W'(rnd[r][1]);
         s3_pb_in[r] = SUM_W'(rnd[r][2]) + trans_sel[r];
         s4_sum_in[r] = s3_pa_ff[r] + s3_pb_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_coord_ff <= in_coord;
         s2_prod_ff  <= s2_prod_in;
         for (int r = 0; r < hpt_pkg::MAT_DIM; r++) begin
            s2_trans_ff[r] <= mat[r][hpt_pkg::MAT_DIM - 1];
         end
         s3_pa_ff  <= s3_pa_in;
         s3_pb_ff  <= s3_pb_in;
         s4_sum_ff <= s4_sum_in;
      end
   end

   assign out_ctl = s4_ctl_ff;
   assign row_sum = s4_sum_ff;

endmodule

>>> hdl/hpt_div.sv
// Sign split and restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module hpt_div #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32,
   parameter int SUM_W       = 2 * COORD_WIDTH - FRAC_BITS + 2,
   parameter int QB          = COORD_WIDTH + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  hpt_pkg::stage_ctl_type  in_ctl,
   input  logic signed [SUM_W-1:0] row_sum [hpt_pkg::MAT_DIM],
   output hpt_pkg::div_ctl_type    out_ctl,
   output hpt_pkg::lane_flag_type  out_flag [hpt_pkg::NUM_LANES],
   output logic [SUM_W-1:0]        out_mag [hpt_pkg::NUM_LANES],
   output logic [QB-1:0]           out_quo [hpt_pkg::NUM_LANES]
);

   localparam int WN = SUM_W + FRAC_BITS + 1;
   localparam int WC = ((WN > SUM_W + QB) ? WN : SUM_W + QB) + 1;

   hpt_pkg::div_ctl_type   d0_ctl_in, d0_ctl_ff;
   hpt_pkg::lane_flag_type d0_flag_in [hpt_pkg::NUM_LANES];
   hpt_pkg::lane_flag_type d0_flag_ff [hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]       d0_mag_in [hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]       d0_mag_ff [hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]       d0_den_in, d0_den_ff;

   hpt_pkg::div_ctl_type   stg_ctl_in [QB+1];
   hpt_pkg::div_ctl_type   stg_ctl_ff [QB+1];
   hpt_pkg::lane_flag_type stg_flag_in [QB+1][hpt_pkg::NUM_LANES];
   hpt_pkg::lane_flag_type stg_flag_ff [QB+1][hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]       stg_mag_in [QB+1][hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]       stg_mag_ff [QB+1][hpt_pkg::NUM_LANES];
   logic [WN-1:0]          stg_rem_in [QB+1][hpt_pkg::NUM_LANES];
   logic [WN-1:0]          stg_rem_ff [QB+1][hpt_pkg::NUM_LANES];
   logic [QB-1:0]          stg_quo_in [QB+1][hpt_pkg::NUM_LANES];
   logic [QB-1:0]          stg_quo_ff [QB+1][hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]       stg_den_in [QB+1];
   logic [SUM_W-1:0]       stg_den_ff [QB+1];

   logic w_neg;

   // Split each sum into sign and magnitude; point mode takes the sign of x xor w.
   always_comb begin
      w_neg = row_sum[hpt_pkg::MAT_DIM - 1][SUM_W-1];
      d0_den_in = w_neg ? unsigned'(-row_sum[hpt_pkg::MAT_DIM - 1])
                        : unsigned'(row_sum[hpt_pkg::MAT_DIM - 1]);
      d0_ctl_in.vld  = in_ctl.vld;
      d0_ctl_in.kind = in_ctl.kind;
      d0_ctl_in.wz   = (in_ctl.kind == hpt_pkg::REQ_POINT) &&
                       (row_sum[hpt_pkg::MAT_DIM - 1] == '0);
      for (int i = 0; i < hpt_pkg::NUM_LANES; i++) begin
         d0_mag_in[i] = row_sum[i][SUM_W-1] ? unsigned'(-row_sum[i])
                                            : unsigned'(row_sum[i]);
         if (in_ctl.kind == hpt_pkg::REQ_DIRECTION) begin
            d0_flag_in[i].neg = row_sum[i][SUM_W-1];
         end else begin
            d0_flag_in[i].neg = row_sum[i][SUM_W-1] ^ w_neg;
         end
         d0_flag_in[i].ovf = 1'b0;
      end
   end

   // The dividend is the magnitude scaled by one more bit than the fraction,
   // so the last quotient bit serves for rounding.
   always_comb begin
      logic [WC-1:0] wide;
      logic [WC-1:0] sub;
      logic [WN-1:0] num;
      stg_ctl_in[0] = d0_ctl_ff;
      stg_den_in[0] = d0_den_ff;
      for (int i = 0; i < hpt_pkg::NUM_LANES; i++) begin
         num = WN'(d0_mag_ff[i]) << (FRAC_BITS + 1);
         stg_mag_in[0][i]     = d0_mag_ff[i];
         stg_rem_in[0][i]     = num;
         stg_quo_in[0][i]     = '0;
         stg_flag_in[0][i].neg = d0_flag_ff[i].neg;
         stg_flag_in[0][i].ovf = WC'(num) >= (WC'(d0_den_ff) << QB);
      end
      for (int j = 0; j < QB; j++) begin
         stg_ctl_in[j+1] = stg_ctl_ff[j];
         stg_den_in[j+1] = stg_den_ff[j];
         for (int i = 0; i < hpt_pkg::NUM_LANES; i++) begin
            stg_flag_in[j+1][i] = stg_flag_ff[j][i];
            stg_mag_in[j+1][i]  = stg_mag_ff[j][i];
            wide = WC'(stg_rem_ff[j][i]);
            sub  = WC'(stg_den_ff[j]) << (QB - 1 - j);
            if (wide >= sub) begin
               stg_rem_in[j+1][i] = WN'(wide - sub);
               stg_quo_in[j+1][i] = stg_quo_ff[j][i] | (QB'(1) << (QB - 1 - j));
            end else begin
               stg_rem_in[j+1][i] = stg_rem_ff[j][i];
               stg_quo_in[j+1][i] = stg_quo_ff[j][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_ctl_ff <= '0;
         for (int j = 0; j <= QB; j++) begin
            stg_ctl_ff[j] <= '0;
         end
      end else if (en) begin
         d0_ctl_ff  <= d0_ctl_in;
         stg_ctl_ff <= stg_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_flag_ff  <= d0_flag_in;
         d0_mag_ff   <= d0_mag_in;
         d0_den_ff   <= d0_den_in;
         stg_flag_ff <= stg_flag_in;
         stg_mag_ff  <= stg_mag_in;
         stg_rem_ff  <= stg_rem_in;
         stg_quo_ff  <= stg_quo_in;
         stg_den_ff  <= stg_den_in;
      end
   end

   assign out_ctl  = stg_ctl_ff[QB];
   assign out_flag = stg_flag_ff[QB];
   assign out_mag  = stg_mag_ff[QB];
   assign out_quo  = stg_quo_ff[QB];

endmodule

>>> hdl/homogeneous_point_transform.sv
// Throughput: one item per cycle while no stall holds the pipeline; the restoring
// divider retires one quotient bit per stage, which sets the depth of the pipeline.
// An accepted item passes the matrix stages, the divider stages and the output register.
// A stalled result stops the pipeline only while its last stage also holds an item.
// Reset is synchronous and active high; it empties the pipeline and loads the
// identity matrix into the configuration registers.
`timescale 1ns / 1ps

module homogeneous_point_transform #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [95:0]                 req_tdata,   // in_x, in_y, in_z
   input  logic [0:0]                  req_tuser,   // req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [95:0]                 rsp_tdata,   // out_x, out_y, out_z
   output logic [1:0]                  rsp_tuser,   // w_zero, saturated
   input  logic                        csr_we,
   input  logic [hpt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [hpt_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int SUM_W = ((2 * COORD_WIDTH - FRAC_BITS > COORD_WIDTH) ?
                           2 * COORD_WIDTH - FRAC_BITS : COORD_WIDTH) + 2;
   localparam int QB = COORD_WIDTH + 1;
   localparam int MW = ((SUM_W > QB) ? SUM_W : QB) + 1;
   localparam int HALF_STRIDE = hpt_pkg::CSR_W / 2;
   localparam logic [COORD_WIDTH-1:0] ONE_FIX = COORD_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic [MW-1:0] POS_LIM = (MW'(1) << (COORD_WIDTH - 1)) - MW'(1);
   localparam logic [MW-1:0] NEG_LIM = MW'(1) << (COORD_WIDTH - 1);
   localparam logic [MW-1:0] QUO_OVF = MW'(1) << QB;

   logic signed [COORD_WIDTH-1:0] mat_in [hpt_pkg::MAT_DIM][hpt_pkg::MAT_DIM];
   logic signed [COORD_WIDTH-1:0] mat_ff [hpt_pkg::MAT_DIM][hpt_pkg::MAT_DIM];

   logic                          en;
   hpt_pkg::stage_ctl_type        in_ctl, xf_ctl;
   logic signed [COORD_WIDTH-1:0] in_coord [hpt_pkg::NUM_LANES];
   logic signed [SUM_W-1:0]       row_sum [hpt_pkg::MAT_DIM];
   hpt_pkg::div_ctl_type          dv_ctl;
   hpt_pkg::lane_flag_type        dv_flag [hpt_pkg::NUM_LANES];
   logic [SUM_W-1:0]              dv_mag [hpt_pkg::NUM_LANES];
   logic [QB-1:0]                 dv_quo [hpt_pkg::NUM_LANES];

   logic                          out_vld_ff;
   logic [hpt_pkg::FIELD_W-1:0]   out_coord_in [hpt_pkg::NUM_LANES];
   logic [hpt_pkg::FIELD_W-1:0]   out_coord_ff [hpt_pkg::NUM_LANES];
   logic                          out_wz_in, out_wz_ff;
   logic                          out_sat_in, out_sat_ff;

   // Configuration registers: each write carries two matrix entries.
   always_comb begin
      mat_in = mat_ff;
      if (csr_we) begin
         mat_in[csr_addr[2:1]][{csr_addr[0], 1'b0}] = csr_wdata[COORD_WIDTH-1:0];
         mat_in[csr_addr[2:1]][{csr_addr[0], 1'b1}] =
            csr_wdata[HALF_STRIDE +: COORD_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < hpt_pkg::MAT_DIM; r++) begin
            for (int c = 0; c < hpt_pkg::MAT_DIM; c++) begin
               mat_ff[r][c] <= (r == c) ? ONE_FIX : '0;
            end
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   assign en         = !(dv_ctl.vld && out_vld_ff && !rsp_tready);
   assign req_tready = en;

   assign in_ctl.vld  = req_tvalid;
   assign in_ctl.kind = hpt_pkg::req_kind_type'(req_tuser[0]);
   assign in_coord[0] = req_tdata[COORD_WIDTH-1:0];
   assign in_coord[1] = req_tdata[hpt_pkg::FIELD_W +: COORD_WIDTH];
   assign in_coord[2] = req_tdata[2 * hpt_pkg::FIELD_W +: COORD_WIDTH];

   hpt_xform #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH),
      .SUM_W       (SUM_W)
   ) u_xform (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (in_ctl),
      .in_coord (in_coord),
      .mat      (mat_ff),
      .out_ctl  (xf_ctl),
      .row_sum  (row_sum)
   );

   hpt_div #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH),
      .SUM_W       (SUM_W),
      .QB          (QB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (xf_ctl),
      .row_sum  (row_sum),
      .out_ctl  (dv_ctl),
      .out_flag (dv_flag),
      .out_mag  (dv_mag),
      .out_quo  (dv_quo)
   );

   // Final rounding of the quotient, clamping and sign restore.
   always_comb begin
      logic [MW-1:0]                 mag;
      logic [MW-1:0]                 lim;
      logic [QB:0]                   rq;
      logic [MW-1:0]                 sval;
      logic signed [COORD_WIDTH-1:0] res;
      out_wz_in  = dv_ctl.wz;
      out_sat_in = 1'b0;
      for (int i = 0; i < hpt_pkg::NUM_LANES; i++) begin
         rq = (QB + 1)'(dv_quo[i]) + (QB + 1)'(1);
         if (dv_ctl.kind == hpt_pkg::REQ_DIRECTION) begin
            mag = MW'(dv_mag[i]);
         end else if (dv_flag[i].ovf) begin
            mag = QUO_OVF;
         end else begin
            mag = MW'(rq >> 1);
         end
         lim = dv_flag[i].neg ? NEG_LIM : POS_LIM;
         if (mag > lim) begin
            mag = lim;
            if (!dv_ctl.wz) begin
               out_sat_in = 1'b1;
            end
         end
         sval = dv_flag[i].neg ? (MW'(0) - mag) : mag;
         res  = COORD_WIDTH'(sval);
         if (dv_ctl.wz) begin
            out_coord_in[i] = '0;
         end else begin
            out_coord_in[i] = hpt_pkg::FIELD_W'(res);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         out_vld_ff <= dv_ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_coord_ff <= out_coord_in;
         out_wz_ff    <= out_wz_in;
         out_sat_ff   <= out_sat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_coord_ff[2], out_coord_ff[1], out_coord_ff[0]};
   assign rsp_tuser  = {out_sat_ff, out_wz_ff};

`ifndef SYNTHESIS
   localparam logic [hpt_pkg::FIELD_W-1:0] OUT_HI =
      hpt_pkg::FIELD_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic [hpt_pkg::FIELD_W-1:0] OUT_LO = ~OUT_HI;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_wz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0 && !rsp_tuser[1]))
      else $error("w zero result carries data or saturation");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (out_coord_ff[0] == OUT_HI || out_coord_ff[0] == OUT_LO ||
          out_coord_ff[1] == OUT_HI || out_coord_ff[1] == OUT_LO ||
          out_coord_ff[2] == OUT_HI || out_coord_ff[2] == OUT_LO))
      else $error("saturated item has no coordinate at a range limit");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      (dv_ctl.vld && out_vld_ff && !rsp_tready) |=> (dv_ctl.vld && !req_tready ||
                                                     dv_ctl.vld && rsp_tready))
      else $error("last pipeline item lost during a stall");
`endif

endmodule

>>> bench/homogeneous_point_transform_tb.sv
// Self-checking testbench for the homogeneous point transform.
`timescale 1ns / 1ps

module homogeneous_point_transform_tb;

   localparam int FRAC = 16;
   localparam int COORD_W = 32;
   localparam int PIPE_LATENCY = COORD_W + 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETS_PER_PHASE = 8;
   localparam int ITEMS_PER_SET = 42;

   localparam logic [31:0] ONE_Q = 32'h0001_0000;
   localparam logic [31:0] HALF_Q = 32'h0000_8000;
   localparam logic [31:0] MAX_Q = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_Q = 32'h8000_0000;
   localparam longint HALF_LSB = 64'sd1 <<< (FRAC - 1);
   localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   typedef enum int {
      ROW0_COLS01 = 0,
      ROW0_COLS23 = 1,
      ROW1_COLS01 = 2,
      ROW1_COLS23 = 3,
      ROW2_COLS01 = 4,
      ROW2_COLS23 = 5,
      ROW3_COLS01 = 6,
      ROW3_COLS23 = 7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic        w_zero;
      logic        saturated;
   } vertex_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [95:0]             req_tdata;
   logic [0:0]              req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [95:0]             rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    csr_we;
   logic [hpt_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [hpt_pkg::CSR_W-1:0]      csr_wdata;

   // Matrix as the block holds it, and the one about to be written.
   logic [63:0]             matrix_regs [hpt_pkg::NUM_REGS];
   logic [63:0]             next_regs [hpt_pkg::NUM_REGS];
   vertex_result_type       pending_vertices [$];
   int                      mismatch_count = 0;
   int                      cycle_count = 0;
   int                      idle_pct = 0;
   int                      stall_pct = 0;

   homogeneous_point_transform #(
      .FRAC_BITS(FRAC),
      .COORD_WIDTH(COORD_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // ---------------- prediction ----------------

   function automatic longint entry_of(int r, int c);
      logic [63:0]        word;
      logic signed [31:0] half;
      word = matrix_regs[r * 2 + c / 2];
      half = (c % 2) ? word[63:32] : word[31:0];
      return half;
   endfunction

   function automatic longint round_product(longint a, longint b);
      return (a * b + HALF_LSB) >>> FRAC;
   endfunction

   function automatic longint row_value(int r, longint vx, longint vy, longint vz,
                                        bit with_offset);
      longint s;
      s = round_product(entry_of(r, 0), vx) + round_product(entry_of(r, 1), vy)
        + round_product(entry_of(r, 2), vz);
      if (with_offset) s += entry_of(r, 3);
      return s;
   endfunction

   // Quotient num * 2^FRAC / den on magnitudes, halves rounded away from zero.
   function automatic longint divide_by_w(longint num, longint den);
      longint unsigned n, d, q, rem;
      longint          mag;
      bit              neg;
      int              i;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      rem = n % d;
      if (q >= (64'd1 << COORD_W)) begin
         q = 64'd1 << (COORD_W + FRAC);
      end else begin
         for (i = 0; i < FRAC; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
               rem -= d;
               q |= 64'd1;
            end
         end
         rem = rem << 1;
         if (rem >= d) q += 64'd1;
      end
      mag = q;
      return neg ? -mag : mag;
   endfunction

   function automatic logic [31:0] clamp_coord(longint v, inout bit flag);
      if (v > COORD_MAX) begin
         flag = 1'b1;
         return MAX_Q;
      end
      if (v < COORD_MIN) begin
         flag = 1'b1;
         return MIN_Q;
      end
      return v[31:0];
   endfunction

   function automatic vertex_result_type transform_vertex(hpt_pkg::req_kind_type kind,
                                                          logic [31:0] x,
                                                          logic [31:0] y, logic [31:0] z);
      vertex_result_type  res;
      logic signed [31:0] sx, sy, sz;
      longint             vx, vy, vz, w;
      bit                 sat;
      sx = x;
      sy = y;
      sz = z;
      vx = sx;
      vy = sy;
      vz = sz;
      sat = 1'b0;
      res = '0;
      if (kind == hpt_pkg::REQ_POINT) begin
         w = row_value(3, vx, vy, vz, 1'b1);
         if (w == 0) begin
            res.w_zero = 1'b1;
         end else begin
            res.out_x = clamp_coord(divide_by_w(row_value(0, vx, vy, vz, 1'b1), w), sat);
            res.out_y = clamp_coord(divide_by_w(row_value(1, vx, vy, vz, 1'b1), w), sat);
            res.out_z = clamp_coord(divide_by_w(row_value(2, vx, vy, vz, 1'b1), w), sat);
         end
      end else begin
         res.out_x = clamp_coord(row_value(0, vx, vy, vz, 1'b0), sat);
         res.out_y = clamp_coord(row_value(1, vx, vy, vz, 1'b0), sat);
         res.out_z = clamp_coord(row_value(2, vx, vy, vz, 1'b0), sat);
      end
      res.saturated = sat;
      return res;
   endfunction

   // ---------------- checking ----------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      vertex_result_type want;
      vertex_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_x = rsp_tdata[31:0];
         got.out_y = rsp_tdata[63:32];
         got.out_z = rsp_tdata[95:64];
         got.w_zero = rsp_tuser[0];
         got.saturated = rsp_tuser[1];
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = pending_vertices.pop_front();
            check_field("out_x", want.out_x, got.out_x);
            check_field("out_y", want.out_y, got.out_y);
            check_field("out_z", want.out_z, got.out_z);
            check_field("w_zero", want.w_zero, got.w_zero);
            check_field("saturated", want.saturated, got.saturated);
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic void put_entry(int r, int c, logic [31:0] v);
      if (c % 2) next_regs[r * 2 + c / 2][63:32] = v;
      else next_regs[r * 2 + c / 2][31:0] = v;
   endfunction

   function automatic void identity_shadow();
      next_regs[ROW0_COLS01] = {32'h0, ONE_Q};
      next_regs[ROW0_COLS23] = 64'h0;
      next_regs[ROW1_COLS01] = {ONE_Q, 32'h0};
      next_regs[ROW1_COLS23] = 64'h0;
      next_regs[ROW2_COLS01] = 64'h0;
      next_regs[ROW2_COLS23] = {32'h0, ONE_Q};
      next_regs[ROW3_COLS01] = 64'h0;
      next_regs[ROW3_COLS23] = {ONE_Q, 32'h0};
   endfunction

   function automatic logic [31:0] random_entry();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return MAX_Q;
         2: return MIN_Q;
         3, 4: return $urandom();
         default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: return 32'h0;
               1: return MAX_Q;
               2: return MIN_Q;
               3: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         end
         1, 2: return $urandom();
         default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
      endcase
   endfunction

   // Called and left at a falling edge; valid stays high between back-to-back items.
   task automatic send_vertex(hpt_pkg::req_kind_type kind, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_vertices.push_back(transform_vertex(kind, x, y, z));
      @(negedge clock);
   endtask

   // The matrix is only rewritten once every outstanding item has come back.
   task automatic commit_matrix();
      int i;
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      @(negedge clock);
      for (i = 0; i < hpt_pkg::NUM_REGS; i++) begin
         csr_we <= 1'b1;
         csr_addr <= hpt_pkg::CSR_ADDR_W'(i);
         csr_wdata <= next_regs[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      matrix_regs = next_regs;
   endtask

   // ---------------- tests ----------------

   task automatic test_identity_passthrough();
      send_vertex(hpt_pkg::REQ_POINT, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000);
      send_vertex(hpt_pkg::REQ_DIRECTION, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000);
      send_vertex(hpt_pkg::REQ_POINT, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_coordinate_extremes();
      send_vertex(hpt_pkg::REQ_POINT, MAX_Q, MIN_Q, 32'hFFFF_FFFF);
      send_vertex(hpt_pkg::REQ_DIRECTION, MAX_Q, MIN_Q, 32'hFFFF_FFFF);
      send_vertex(hpt_pkg::REQ_POINT, MIN_Q, MAX_Q, 32'h1);
      send_vertex(hpt_pkg::REQ_DIRECTION, MIN_Q, MAX_Q, 32'h1);
   endtask

   // With w taken straight from x, x = 0 makes w vanish.
   task automatic test_zero_w();
      identity_shadow();
      put_entry(3, 0, ONE_Q);
      put_entry(3, 3, 32'h0);
      commit_matrix();
      send_vertex(hpt_pkg::REQ_POINT, 32'h0, 32'h0005_0000, 32'h0007_0000);
      send_vertex(hpt_pkg::REQ_DIRECTION, 32'h0, 32'h0005_0000, 32'h0007_0000);
      send_vertex(hpt_pkg::REQ_POINT, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
      send_vertex(hpt_pkg::REQ_POINT, 32'hFFFD_0000, ONE_Q, ONE_Q);
   endtask

   task automatic test_saturation();
      identity_shadow();
      put_entry(0, 0, MAX_Q);
      put_entry(1, 1, MIN_Q);
      put_entry(2, 2, MAX_Q);
      put_entry(0, 3, MAX_Q);
      commit_matrix();
      send_vertex(hpt_pkg::REQ_DIRECTION, MAX_Q, MAX_Q, MIN_Q);
      send_vertex(hpt_pkg::REQ_POINT, MAX_Q, MAX_Q, MIN_Q);
      // A w of one LSB overflows the quotient.
      put_entry(3, 3, 32'h1);
      commit_matrix();
      send_vertex(hpt_pkg::REQ_POINT, ONE_Q, ONE_Q, ONE_Q);
      send_vertex(hpt_pkg::REQ_POINT, 32'hFFFF_0000, 32'h0, ONE_Q);
   endtask

   task automatic test_rounding();
      identity_shadow();
      put_entry(0, 0, HALF_Q);
      put_entry(1, 1, HALF_Q);
      put_entry(2, 2, HALF_Q);
      put_entry(3, 3, 32'h0002_0000);
      commit_matrix();
      send_vertex(hpt_pkg::REQ_DIRECTION, 32'h1, 32'hFFFF_FFFF, 32'h3);
      send_vertex(hpt_pkg::REQ_POINT, 32'h1, 32'hFFFF_FFFF, 32'h3);
      send_vertex(hpt_pkg::REQ_POINT, 32'hFFFF_FFFD, 32'hFFFF_FFFB, 32'h5);
   endtask

   task automatic test_random_sweep(int idle, int stall, int sets);
      int                    s, k, r, c, style;
      logic [31:0]           offset, x;
      hpt_pkg::req_kind_type kind;
      idle_pct = idle;
      stall_pct = stall;
      for (s = 0; s < sets; s++) begin
         for (r = 0; r < 3; r++) begin
            for (c = 0; c < 4; c++) put_entry(r, c, random_entry());
         end
         style = $urandom_range(3);
         offset = ($urandom_range(64) - 32) << FRAC;
         case (style)
            0: begin
               put_entry(3, 0, 32'h0);
               put_entry(3, 1, 32'h0);
               put_entry(3, 2, 32'h0);
               put_entry(3, 3, ONE_Q);
            end
            // w = x + offset, so x = -offset gives a zero w.
            1: begin
               put_entry(3, 0, ONE_Q);
               put_entry(3, 1, 32'h0);
               put_entry(3, 2, 32'h0);
               put_entry(3, 3, offset);
            end
            2: begin
               for (c = 0; c < 4; c++) put_entry(3, c, random_entry());
            end
            default: begin
               for (c = 0; c < 3; c++) put_entry(3, c, $urandom_range(32'h2000) - 32'h1000);
               put_entry(3, 3, ONE_Q);
            end
         endcase
         commit_matrix();
         for (k = 0; k < ITEMS_PER_SET; k++) begin
            kind = ($urandom_range(99) < 60) ? hpt_pkg::REQ_POINT : hpt_pkg::REQ_DIRECTION;
            x = random_coord();
            if (style == 1 && $urandom_range(3) == 0) x = 32'h0 - offset;
            send_vertex(kind, x, random_coord(), random_coord());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      identity_shadow();
      matrix_regs = next_regs;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identity_passthrough();
      test_coordinate_extremes();
      test_zero_w();
      test_saturation();
      test_rounding();
      test_random_sweep(0, 0, SETS_PER_PHASE);
      test_random_sweep(45, 0, SETS_PER_PHASE);
      test_random_sweep(0, 45, SETS_PER_PHASE);
      test_random_sweep(25, 25, SETS_PER_PHASE);

      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
